// ===== hw/rtl/kts_pkg.sv =====
`default_nettype none

package kts_pkg;

  localparam int FEAT_W         = 16;
  localparam int NUM_CL         = 3;
  localparam int NUM_DIM        = 3;
  localparam int DIST_W         = 2 * FEAT_W + 2;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int PNUM_W         = 10;
  localparam int MCNT_W         = 11;
  localparam int LABEL_W        = 2;
  localparam int IDX_W          = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = NUM_DIM * FEAT_W;

  localparam logic [FEAT_W-1:0] ONE_Q88 = FEAT_W'(16'h0100);

  localparam logic [CFG_DATA_W-1:0] CENT_INIT [NUM_CL] = '{
    48'h1500_0300_1600,
    48'h1700_0500_1500,
    48'h1700_0400_1500
  };

  typedef enum logic [LABEL_W-1:0] {
    CL_NORMAL      = 2'd0,
    CL_VENTRICULAR = 2'd1,
    CL_ARTIFACT    = 2'd2
  } cluster_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL      = 2'd0,
    CFG_VENTRICULAR = 2'd1,
    CFG_ARTIFACT    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REC_LABEL    = 1'b0,
    REC_CENTROID = 1'b1
  } rec_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DIST_WAIT,
    ST_DECIDE,
    ST_LABEL,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_CEN_OUT
  } state_e;

  typedef struct packed {
    logic     valid;
    logic     first;
    logic     last;
    cluster_e cluster;
  } dist_cmd_t;

  typedef struct packed {
    logic     valid;
    cluster_e cluster;
  } dist_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kts_if.sv =====
`default_nettype none

interface kts_in_if;
  logic                      valid;
  logic                      ready;
  logic [kts_pkg::FEAT_W-1:0] feature_a;
  logic [kts_pkg::FEAT_W-1:0] feature_b;
  logic [kts_pkg::FEAT_W-1:0] feature_c;
  logic                      last_point;

  modport source (output valid, feature_a, feature_b, feature_c, last_point, input ready);
  modport sink   (input valid, feature_a, feature_b, feature_c, last_point, output ready);
endinterface

interface kts_out_if;
  logic                        valid;
  logic                        ready;
  logic                        record_kind;
  logic [kts_pkg::PNUM_W-1:0]  point_number;
  logic [kts_pkg::LABEL_W-1:0] cluster_label;
  logic [kts_pkg::FEAT_W-1:0]  centroid_a;
  logic [kts_pkg::FEAT_W-1:0]  centroid_b;
  logic [kts_pkg::FEAT_W-1:0]  centroid_c;
  logic [kts_pkg::MCNT_W-1:0]  member_count;
  logic                        last_result;

  modport source (output valid, record_kind, point_number, cluster_label, centroid_a,
                  centroid_b, centroid_c, member_count, last_result, input ready);
  modport sink   (input valid, record_kind, point_number, cluster_label, centroid_a,
                  centroid_b, centroid_c, member_count, last_result, output ready);
endinterface

interface kts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kts_pkg::CFG_IDX_W-1:0]  index;
  logic [kts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kmeans_three_cluster_step.sv =====
// Channel  Dir  Handshake    Payload
// in_i     in   valid/ready  feature_a, feature_b, feature_c, last_point
// out_o    out  valid/ready  record_kind, point_number, cluster_label, centroid_a/b/c,
//                            member_count, last_result
// cfg_i    in   valid/ready  index, data (ready always high)
//
// A point takes 9 passes through the shared square-accumulate unit (one coordinate of
// one centroid per cycle), its 3-stage pipeline, a compare and a label.
// A closing point adds up to 9 serial divisions in the shared divider, skipping those of
// empty clusters, plus one record per centroid.
// Reset loads the default centroids and clears sums, counts and the point counter.
// One output register; the sequencer waits while a record is still held there.
`default_nettype none

module kmeans_three_cluster_step #(
  parameter int MAX_POINTS = kts_pkg::MAX_POINTS_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  kts_in_if.sink    in_i,
  kts_out_if.source out_o,
  kts_cfg_if.sink   cfg_i
);

  localparam int FW    = kts_pkg::FEAT_W;
  localparam int PC_W  = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = FW + CNT_W;
  localparam int IW    = kts_pkg::IDX_W;
  localparam int NCL   = kts_pkg::NUM_CL;
  localparam int NDIM  = kts_pkg::NUM_DIM;

  kts_pkg::state_e state_q, state_d;
  logic [IW-1:0] c_q, c_d, k_q, k_d;

  logic [FW-1:0]             pt_q   [NDIM];
  logic                      last_q;
  logic [FW-1:0]             cen_q  [NCL][NDIM];
  logic [SUM_W-1:0]          sum_q  [NCL][NDIM];
  logic [CNT_W-1:0]          cnt_q  [NCL];
  logic [PC_W-1:0]           pc_q;
  logic [kts_pkg::DIST_W-1:0] dist_q [NCL];
  kts_pkg::cluster_e         label_q, label_d;
  logic [FW-1:0]             mean_q [NDIM];

  kts_pkg::dist_cmd_t        mac_cmd;
  kts_pkg::dist_rsp_t        mac_rsp;
  logic [kts_pkg::DIST_W-1:0] mac_acc;

  logic                      div_start, div_done;
  logic [FW-1:0]             div_quot;

  logic                      emit_label, emit_cen, mean_wr, close, out_free, clr_all;
  logic [FW-1:0]             mean_val;
  logic [IW-1:0]             row_sel;
  logic [SUM_W-1:0]          row_sum [NDIM];
  logic [CNT_W-1:0]          row_cnt;

  logic                      out_vld_q;
  kts_pkg::rec_kind_e        out_kind_q;
  logic [kts_pkg::PNUM_W-1:0] out_pnum_q;
  kts_pkg::cluster_e         out_label_q;
  logic [FW-1:0]             out_cen_q [NDIM];
  logic [kts_pkg::MCNT_W-1:0] out_cnt_q;
  logic                      out_last_q;

  logic [PC_W+kts_pkg::PNUM_W-1:0]  pnum_ext;
  logic [CNT_W+kts_pkg::MCNT_W-1:0] cnt_ext;
  logic                      cfg_hit;

  assign close    = last_q || (pc_q == PC_W'(MAX_POINTS - 1));
  assign out_free = !out_vld_q || out_o.ready;
  assign clr_all  = emit_cen && (c_q == IW'(NCL - 1));
  assign row_sel  = (state_q == kts_pkg::ST_LABEL) ? IW'(label_q) : c_q;
  assign row_cnt  = cnt_q[row_sel];
  assign pnum_ext = {{kts_pkg::PNUM_W{1'b0}}, pc_q};
  assign cnt_ext  = {{kts_pkg::MCNT_W{1'b0}}, row_cnt};
  assign cfg_hit  = cfg_i.valid && (cfg_i.index == kts_pkg::CFG_NORMAL ||
                                    cfg_i.index == kts_pkg::CFG_VENTRICULAR ||
                                    cfg_i.index == kts_pkg::CFG_ARTIFACT);

  always_comb begin
    for (int k = 0; k < NDIM; k++) begin
      row_sum[k] = sum_q[row_sel][k];
    end
  end

  kts_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (cen_q[c_q][k_q]),
    .b_i    (pt_q[k_q]),
    .acc_o  (mac_acc),
    .rsp_o  (mac_rsp)
  );

  kts_div #(
    .DVS_W (CNT_W),
    .Q_W   (FW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (row_sum[k_q] + SUM_W'(row_cnt >> 1)),
    .divisor_i  (row_cnt),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    priority if (dist_q[0] <= dist_q[1] && dist_q[0] <= dist_q[2]) begin
      label_d = kts_pkg::CL_NORMAL;
    end else if (dist_q[1] <= dist_q[2]) begin
      label_d = kts_pkg::CL_VENTRICULAR;
    end else begin
      label_d = kts_pkg::CL_ARTIFACT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kts_pkg::ST_IDLE;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    c_d        = c_q;
    k_d        = k_q;
    mac_cmd    = '0;
    div_start  = 1'b0;
    emit_label = 1'b0;
    emit_cen   = 1'b0;
    mean_wr    = 1'b0;
    mean_val   = div_quot;
    unique case (state_q)
      kts_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = kts_pkg::ST_DIST;
          c_d     = '0;
          k_d     = '0;
        end
      end
      kts_pkg::ST_DIST: begin
        mac_cmd.valid   = 1'b1;
        mac_cmd.first   = (k_q == '0);
        mac_cmd.last    = (k_q == IW'(NDIM - 1));
        mac_cmd.cluster = kts_pkg::cluster_e'(c_q);
        if (k_q == IW'(NDIM - 1)) begin
          k_d = '0;
          if (c_q == IW'(NCL - 1)) begin
            state_d = kts_pkg::ST_DIST_WAIT;
          end else begin
            c_d = c_q + IW'(1);
          end
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      kts_pkg::ST_DIST_WAIT: begin
        if (mac_rsp.valid && mac_rsp.cluster == kts_pkg::CL_ARTIFACT) begin
          state_d = kts_pkg::ST_DECIDE;
        end
      end
      kts_pkg::ST_DECIDE: begin
        state_d = kts_pkg::ST_LABEL;
      end
      kts_pkg::ST_LABEL: begin
        if (out_free) begin
          emit_label = 1'b1;
          c_d        = '0;
          k_d        = '0;
          state_d    = close ? kts_pkg::ST_DIV_START : kts_pkg::ST_IDLE;
        end
      end
      kts_pkg::ST_DIV_START: begin
        if (row_cnt == '0) begin
          mean_wr  = 1'b1;
          mean_val = kts_pkg::ONE_Q88;
          if (k_q == IW'(NDIM - 1)) begin
            state_d = kts_pkg::ST_CEN_OUT;
          end else begin
            k_d = k_q + IW'(1);
          end
        end else begin
          div_start = 1'b1;
          state_d   = kts_pkg::ST_DIV_RUN;
        end
      end
      kts_pkg::ST_DIV_RUN: begin
        if (div_done) begin
          mean_wr = 1'b1;
          if (k_q == IW'(NDIM - 1)) begin
            state_d = kts_pkg::ST_CEN_OUT;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = kts_pkg::ST_DIV_START;
          end
        end
      end
      kts_pkg::ST_CEN_OUT: begin
        if (out_free) begin
          emit_cen = 1'b1;
          k_d      = '0;
          if (c_q == IW'(NCL - 1)) begin
            c_d     = '0;
            state_d = kts_pkg::ST_IDLE;
          end else begin
            c_d     = c_q + IW'(1);
            state_d = kts_pkg::ST_DIV_START;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      pt_q[0] <= in_i.feature_a;
      pt_q[1] <= in_i.feature_b;
      pt_q[2] <= in_i.feature_c;
      last_q  <= in_i.last_point;
    end
    if (mac_rsp.valid) begin
      dist_q[mac_rsp.cluster] <= mac_acc;
    end
    if (state_q == kts_pkg::ST_DECIDE) begin
      label_q <= label_d;
    end
    if (mean_wr) begin
      mean_q[k_q] <= mean_val;
    end
  end

  // centroid store: defaults at reset, config writes, new means at batch end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCL; c++) begin
        for (int k = 0; k < NDIM; k++) begin
          cen_q[c][k] <= kts_pkg::CENT_INIT[c][k*FW +: FW];
        end
      end
    end else if (cfg_hit) begin
      for (int k = 0; k < NDIM; k++) begin
        cen_q[cfg_i.index][k] <= cfg_i.data[k*FW +: FW];
      end
    end else if (emit_cen) begin
      for (int k = 0; k < NDIM; k++) begin
        cen_q[c_q][k] <= mean_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCL; c++) begin
        cnt_q[c] <= '0;
        for (int k = 0; k < NDIM; k++) begin
          sum_q[c][k] <= '0;
        end
      end
      pc_q <= '0;
    end else if (clr_all) begin
      for (int c = 0; c < NCL; c++) begin
        cnt_q[c] <= '0;
        for (int k = 0; k < NDIM; k++) begin
          sum_q[c][k] <= '0;
        end
      end
      pc_q <= '0;
    end else if (emit_label) begin
      for (int k = 0; k < NDIM; k++) begin
        sum_q[row_sel][k] <= row_sum[k] + SUM_W'(pt_q[k]);
      end
      cnt_q[row_sel] <= row_cnt + CNT_W'(1);
      if (!close) begin
        pc_q <= pc_q + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_label || emit_cen) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_label) begin
      out_kind_q  <= kts_pkg::REC_LABEL;
      out_pnum_q  <= pnum_ext[kts_pkg::PNUM_W-1:0];
      out_label_q <= label_q;
      for (int k = 0; k < NDIM; k++) begin
        out_cen_q[k] <= '0;
      end
      out_cnt_q   <= '0;
      out_last_q  <= !close;
    end else if (emit_cen) begin
      out_kind_q  <= kts_pkg::REC_CENTROID;
      out_pnum_q  <= '0;
      out_label_q <= kts_pkg::cluster_e'(c_q);
      for (int k = 0; k < NDIM; k++) begin
        out_cen_q[k] <= mean_q[k];
      end
      out_cnt_q   <= cnt_ext[kts_pkg::MCNT_W-1:0];
      out_last_q  <= (c_q == IW'(NCL - 1));
    end
  end

  assign in_i.ready          = (state_q == kts_pkg::ST_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign out_o.valid         = out_vld_q;
  assign out_o.record_kind   = out_kind_q;
  assign out_o.point_number  = out_pnum_q;
  assign out_o.cluster_label = out_label_q;
  assign out_o.centroid_a    = out_cen_q[0];
  assign out_o.centroid_b    = out_cen_q[1];
  assign out_o.centroid_c    = out_cen_q[2];
  assign out_o.member_count  = out_cnt_q;
  assign out_o.last_result   = out_last_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a point is in progress");

  a_div_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == kts_pkg::ST_DIV_RUN))
    else $error("divider finished outside a division step");

  a_empty_cluster_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.record_kind == kts_pkg::REC_CENTROID && out_o.member_count == '0)
    |-> (out_o.centroid_a == kts_pkg::ONE_Q88 && out_o.centroid_b == kts_pkg::ONE_Q88 &&
         out_o.centroid_c == kts_pkg::ONE_Q88))
    else $error("empty cluster centroid is not 1.0");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/kts_mac.sv =====
`default_nettype none

module kts_mac (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire kts_pkg::dist_cmd_t    cmd_i,
  input  wire [kts_pkg::FEAT_W-1:0]  a_i,
  input  wire [kts_pkg::FEAT_W-1:0]  b_i,
  output logic [kts_pkg::DIST_W-1:0] acc_o,
  output kts_pkg::dist_rsp_t         rsp_o
);

  kts_pkg::dist_cmd_t s1_q, s2_q;
  kts_pkg::dist_rsp_t rsp_q;

  logic [kts_pkg::FEAT_W-1:0]   diff_q;
  logic [2*kts_pkg::FEAT_W-1:0] prod_q;
  logic [kts_pkg::DIST_W-1:0]   acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      rsp_q <= '0;
    end else begin
      s1_q          <= cmd_i;
      s2_q          <= s1_q;
      rsp_q.valid   <= s2_q.valid & s2_q.last;
      rsp_q.cluster <= s2_q.cluster;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= (a_i > b_i) ? (a_i - b_i) : (b_i - a_i);
    prod_q <= diff_q * diff_q;
    if (s2_q.valid) begin
      if (s2_q.first) begin
        acc_q <= kts_pkg::DIST_W'(prod_q);
      end else begin
        acc_q <= acc_q + kts_pkg::DIST_W'(prod_q);
      end
    end
  end

  assign acc_o = acc_q;
  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/kts_div.sv =====
`default_nettype none

module kts_div #(
  parameter int DVS_W = 11,
  parameter int Q_W   = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire [DVS_W+Q_W-1:0]   dividend_i,
  input  wire [DVS_W-1:0]       divisor_i,
  output logic                  done_o,
  output logic [Q_W-1:0]        quot_o
);

  localparam int STEP_W = $clog2(Q_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [Q_W-1:0]    lo_q;

  logic [DVS_W:0]    trial, diff;
  logic              ge;

  // quotient requires dividend >> Q_W < divisor
  assign trial = {rem_q, lo_q[Q_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(Q_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DVS_W+Q_W-1:Q_W];
      lo_q  <= dividend_i[Q_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      lo_q  <= {lo_q[Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = lo_q;

endmodule

`default_nettype wire

// ===== verif/tb_kmeans_three_cluster_step.sv =====
module tb_kmeans_three_cluster_step;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 200;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_POINTS = 300;
  localparam int RANDOM_PHASES = 6;

  localparam int FW     = kts_pkg::FEAT_W;
  localparam int NCL    = kts_pkg::NUM_CL;
  localparam int NDIM   = kts_pkg::NUM_DIM;
  localparam int CIDX_W = kts_pkg::CFG_IDX_W;
  localparam int CDAT_W = kts_pkg::CFG_DATA_W;

  localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [FW-1:0]     FEAT_MAX     = '1;

  typedef enum int {RDY_FULL, RDY_COIN, RDY_SPARSE, RDY_PATTERN} ready_mode_e;

  typedef struct packed {
    logic [FW-1:0] fa, fb, fc;
  } beat_t;

  typedef struct packed {
    kts_pkg::rec_kind_e         kind;
    logic [kts_pkg::PNUM_W-1:0] pnum;
    kts_pkg::cluster_e          label;
    logic [FW-1:0]              ca, cb, cc;
    logic [kts_pkg::MCNT_W-1:0] members;
    logic                       tail;
  } cluster_rec_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kts_in_if  in_if ();
  kts_out_if out_if ();
  kts_cfg_if cfg_if ();

  kmeans_three_cluster_step dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // centroid tracker state
  logic [FW-1:0]              centroid_q [NCL][NDIM];
  logic [31:0]                sum_q      [NCL][NDIM];
  logic [kts_pkg::MCNT_W-1:0] members_q  [NCL];
  logic [kts_pkg::PNUM_W-1:0] point_idx_q;
  cluster_rec_t               pending_recs [$];

  int error_count    = 0;
  int report_count   = 0;
  int points_seen    = 0;
  int batches_closed = 0;
  int recs_checked   = 0;
  int cfg_writes     = 0;
  int idle_cycles    = 0;
  int burst_left     = 0;
  bit sender_gaps    = 1'b1;

  beat_t hotspot [NCL];
  int    spread;

  function automatic void load_centroid(logic [CIDX_W-1:0] idx,
                                        logic [CDAT_W-1:0] value);
    if (idx < NCL) begin
      for (int k = 0; k < NDIM; k++) centroid_q[idx][k] = value[k*FW +: FW];
    end
  endfunction

  function automatic void clear_batch();
    for (int c = 0; c < NCL; c++) begin
      members_q[c] = '0;
      for (int k = 0; k < NDIM; k++) sum_q[c][k] = '0;
    end
    point_idx_q = '0;
  endfunction

  function automatic void queue_rec(cluster_rec_t rec);
    pending_recs.insert(pending_recs.size(), rec);
  endfunction

  function automatic void predict_beat(beat_t p, logic last_in);
    logic [FW-1:0]     pt [NDIM];
    longint unsigned   sq [NCL];
    longint unsigned   diff, n, mean;
    kts_pkg::cluster_e lab;
    logic              closing;
    cluster_rec_t      rec;
    pt[0] = p.fa;
    pt[1] = p.fb;
    pt[2] = p.fc;
    for (int c = 0; c < NCL; c++) begin
      sq[c] = 0;
      for (int k = 0; k < NDIM; k++) begin
        diff = (pt[k] > centroid_q[c][k]) ? pt[k] - centroid_q[c][k]
                                           : centroid_q[c][k] - pt[k];
        sq[c] += diff * diff;
      end
    end
    if (sq[0] <= sq[1] && sq[0] <= sq[2]) lab = kts_pkg::CL_NORMAL;
    else if (sq[1] <= sq[2])              lab = kts_pkg::CL_VENTRICULAR;
    else                                  lab = kts_pkg::CL_ARTIFACT;
    for (int k = 0; k < NDIM; k++) sum_q[lab][k] += pt[k];
    members_q[lab] += 1'b1;

    // batch also closes on the last index that fits
    closing = last_in ||
              (point_idx_q == kts_pkg::PNUM_W'(kts_pkg::MAX_POINTS_DEF - 1));
    rec       = '0;
    rec.kind  = kts_pkg::REC_LABEL;
    rec.pnum  = point_idx_q;
    rec.label = lab;
    rec.tail  = !closing;
    queue_rec(rec);
    if (!closing) begin
      point_idx_q += 1'b1;
      return;
    end

    for (int c = 0; c < NCL; c++) begin
      n = members_q[c];
      for (int k = 0; k < NDIM; k++) begin
        mean = (n == 0) ? longint'(kts_pkg::ONE_Q88) : (sum_q[c][k] + n / 2) / n;
        centroid_q[c][k] = mean[FW-1:0];
      end
      rec         = '0;
      rec.kind    = kts_pkg::REC_CENTROID;
      rec.label   = kts_pkg::cluster_e'(c);
      rec.ca      = centroid_q[c][0];
      rec.cb      = centroid_q[c][1];
      rec.cc      = centroid_q[c][2];
      rec.members = members_q[c];
      rec.tail    = (c == NCL - 1);
      queue_rec(rec);
    end
    batches_closed++;
    clear_batch();
  endfunction

  function automatic string rec_str(cluster_rec_t r);
    return $sformatf("kind=%0d pt=%0d cl=%0d cen=%h/%h/%h n=%0d last=%0d",
                     r.kind, r.pnum, r.label, r.ca, r.cb, r.cc, r.members, r.tail);
  endfunction

  function automatic void note_fail(string what, string detail);
    error_count++;
    if (report_count < MAX_REPORTS) begin
      report_count++;
      $display("%t %s: %s", $realtime, what, detail);
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    cluster_rec_t got, want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        load_centroid(cfg_if.index, cfg_if.data);
        cfg_writes++;
      end
      if (in_if.valid && in_if.ready) begin
        predict_beat(beat_t'{in_if.feature_a, in_if.feature_b, in_if.feature_c},
                     in_if.last_point);
        points_seen++;
      end
      if (out_if.valid && out_if.ready) begin
        got.kind    = kts_pkg::rec_kind_e'(out_if.record_kind);
        got.pnum    = out_if.point_number;
        got.label   = kts_pkg::cluster_e'(out_if.cluster_label);
        got.ca      = out_if.centroid_a;
        got.cb      = out_if.centroid_b;
        got.cc      = out_if.centroid_c;
        got.members = out_if.member_count;
        got.tail    = out_if.last_result;
        if (pending_recs.size() == 0) begin
          note_fail("unexpected record", rec_str(got));
        end else begin
          want = pending_recs.pop_front();
          recs_checked++;
          if (got.kind !== want.kind || got.pnum !== want.pnum ||
              got.label !== want.label || got.ca !== want.ca ||
              got.cb !== want.cb || got.cc !== want.cc ||
              got.members !== want.members || got.tail !== want.tail)
            note_fail("mismatch", {"expected ", rec_str(want), " got ", rec_str(got)});
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%t: no item moved for %0d cycles, %0d records pending",
               $realtime, STALL_LIMIT, pending_recs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : out_ready_gen
    ready_mode_e mode;
    int          span;
    logic [7:0]  pattern;
    out_if.ready <= 1'b0;
    forever begin
      mode    = ready_mode_e'($urandom_range(0, 3));
      span    = $urandom_range(10, 60);
      pattern = 8'($urandom) | 8'h01;
      for (int s = 0; s < span; s++) begin
        @(posedge clk_i);
        case (mode)
          RDY_FULL:   out_if.ready <= 1'b1;
          RDY_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:    out_if.ready <= pattern[s % 8];
        endcase
      end
    end
  end

  task automatic send_beat(beat_t p, logic last_in);
    int gap;
    in_if.valid      <= 1'b1;
    in_if.feature_a  <= p.fa;
    in_if.feature_b  <= p.fb;
    in_if.feature_c  <= p.fc;
    in_if.last_point <= last_in;
    do @(posedge clk_i); while (!in_if.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps && $urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 20);
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_recs.size() != 0);
  endtask

  task automatic write_centroid(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [FW-1:0] near(logic [FW-1:0] center);
    int v;
    v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(FEAT_MAX)) v = int'(FEAT_MAX);
    return FW'(v);
  endfunction

  function automatic beat_t random_beat();
    int    pick;
    beat_t p;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      p.fa = near(hotspot[pick % NCL].fa);
      p.fb = near(hotspot[pick % NCL].fb);
      p.fc = near(hotspot[pick % NCL].fc);
    end else if (pick < 17) begin
      p.fa = FW'($urandom);
      p.fb = FW'($urandom);
      p.fc = FW'($urandom);
    end else begin
      p.fa = $urandom_range(0, 1) ? FEAT_MAX : '0;
      p.fb = $urandom_range(0, 1) ? FEAT_MAX : '0;
      p.fc = $urandom_range(0, 1) ? FEAT_MAX : '0;
    end
    return p;
  endfunction

  task automatic test_default_centroids();
    send_beat(beat_t'{16'h1600, 16'h0300, 16'h1500}, 1'b0);
    send_beat(beat_t'{16'h1500, 16'h0500, 16'h1700}, 1'b0);
    send_beat(beat_t'{16'h1500, 16'h0400, 16'h1700}, 1'b0);
    send_beat(beat_t'{16'h0000, 16'h0000, 16'h0000}, 1'b0);
    send_beat(beat_t'{FEAT_MAX, FEAT_MAX, FEAT_MAX}, 1'b0);
    send_beat(beat_t'{16'h1580, 16'h0400, 16'h1600}, 1'b1);
    wait_drained();
  endtask

  task automatic test_tie_breaks();
    write_centroid(kts_pkg::CFG_NORMAL, {3{16'h0600}});
    write_centroid(kts_pkg::CFG_VENTRICULAR, {3{16'h0200}});
    write_centroid(kts_pkg::CFG_ARTIFACT, {3{16'h0200}});
    send_beat(beat_t'{16'h0400, 16'h0400, 16'h0400}, 1'b0);  // three-way tie
    send_beat(beat_t'{16'h0200, 16'h0200, 16'h0200}, 1'b0);  // ventricular = artifact
    send_beat(beat_t'{16'h0600, 16'h0600, 16'h0600}, 1'b1);  // artifact left empty
    write_centroid(kts_pkg::CFG_NORMAL, {3{16'h0800}});
    write_centroid(kts_pkg::CFG_VENTRICULAR, {3{16'h0800}});
    write_centroid(kts_pkg::CFG_ARTIFACT, {3{16'h0800}});
    send_beat(beat_t'{16'h1234, 16'h0000, FEAT_MAX}, 1'b1);  // three-way tie, lone point
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_centroid(kts_pkg::CFG_NORMAL, '0);
    write_centroid(kts_pkg::CFG_VENTRICULAR, '1);
    write_centroid(kts_pkg::CFG_ARTIFACT, {3{16'h8000}});
    write_centroid(CFG_UNMAPPED, CDAT_W'({$urandom, $urandom}));
    send_beat(beat_t'{16'h0000, 16'h0000, 16'h0000}, 1'b0);
    send_beat(beat_t'{FEAT_MAX, FEAT_MAX, FEAT_MAX}, 1'b0);
    send_beat(beat_t'{16'h8000, 16'h8000, 16'h8000}, 1'b0);
    send_beat(beat_t'{16'h4000, 16'h4000, 16'h4000}, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_batch_cap();
    write_centroid(kts_pkg::CFG_NORMAL, '1);
    for (int i = 0; i < kts_pkg::MAX_POINTS_DEF; i++)
      send_beat(beat_t'{FEAT_MAX, FEAT_MAX, FEAT_MAX}, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_batches();
    int   left, batch_len;
    logic closes;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int c = 0; c < NCL; c++) begin
        hotspot[c] = beat_t'(CDAT_W'({$urandom, $urandom}));
        if (phase == 1)
          write_centroid(kts_pkg::cfg_idx_e'(c), '0);
        else if (phase == 2)
          write_centroid(kts_pkg::cfg_idx_e'(c), '1);
        else if (phase > 2)
          write_centroid(kts_pkg::cfg_idx_e'(c), CDAT_W'(hotspot[c]));
      end
      case ($urandom_range(0, 2))
        0:       spread = 16'h0040;
        1:       spread = 16'h0400;
        default: spread = 16'h2000;
      endcase
      sender_gaps = (phase != 3);
      left = RANDOM_POINTS / RANDOM_PHASES;
      while (left > 0) begin
        batch_len = $urandom_range(1, 30);
        if (batch_len > left) batch_len = left;
        for (int i = 0; i < batch_len; i++) begin
          closes = (i == batch_len - 1) ? ($urandom_range(0, 7) != 0)
                                        : ($urandom_range(0, 31) == 0);
          send_beat(random_beat(), closes);
        end
        left -= batch_len;
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
      wait_drained();
    end
    sender_gaps = 1'b1;
  endtask

  initial begin : stimulus
    in_if.valid      <= 1'b0;
    in_if.feature_a  <= '0;
    in_if.feature_b  <= '0;
    in_if.feature_c  <= '0;
    in_if.last_point <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    for (int c = 0; c < NCL; c++) load_centroid(CIDX_W'(c), kts_pkg::CENT_INIT[c]);
    clear_batch();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_centroids();
    test_tie_breaks();
    test_config_extremes();
    test_full_batch_cap();
    test_random_batches();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_recs.size() != 0)
      note_fail("records never arrived", $sformatf("%0d outstanding", pending_recs.size()));
    $display("Ran %0d points through %0d closed batches with %0d centroid writes;",
             points_seen, batches_closed, cfg_writes);
    $display("checked %0d records, %0d failures", recs_checked, error_count);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== kmeans_three_cluster_step.f =====
hw/rtl/kts_pkg.sv
hw/rtl/kts_if.sv
hw/rtl/kts_mac.sv
hw/rtl/kts_div.sv
hw/rtl/kmeans_three_cluster_step.sv
verif/tb_kmeans_three_cluster_step.sv
